// ----- rtl/core/soac_pkg.sv -----
// ----------------------------------------------------------------------------
// soac_pkg
// Shared types, constants and helper functions for the obstacle-avoiding
// stepper controller.
// ----------------------------------------------------------------------------
package soac_pkg;

    // Run modes reported on the result channel.
    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_TURN = 2'd2
    } t_mode;

    // Event kinds carried by an input request.
    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_ECHO  = 2'd1,
        KIND_START = 2'd2,
        KIND_STOP  = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic CFG_TURN_STEPS = 1'b0;
    localparam logic CFG_NEAR_CM    = 1'b1;

    // Configuration reset values.
    localparam logic [7:0] TURN_STEPS_RST = 8'd70;
    localparam logic [7:0] NEAR_CM_RST    = 8'd10;

    // Phase value meaning the wheel has not been stepped yet.
    localparam logic [2:0] PHASE_NONE = 3'd7;

    // Echo counts above this limit are treated as a fault.
    localparam logic [15:0] ECHO_LIMIT = 16'd65000;
    // From this count on, count*32/29 reaches 256 and saturates.
    localparam logic [15:0] ECHO_SAT_TICKS = 16'd232;
    // Reciprocal of 29 scaled by 2^16, exact for numerators below 7424.
    localparam logic [11:0] RECIP_29 = 12'd2260;

    // Controller state carried from one event to the next.
    typedef struct packed {
        t_mode       mode;
        logic [7:0]  turn_count;
        logic [2:0]  phase_a;
        logic [2:0]  phase_b;
        logic [7:0]  distance;
        logic [3:0]  drive_a;
        logic [3:0]  drive_b;
    } t_state;

    // One step forward; the first step lands on phase 0.
    function automatic logic [2:0] phase_fwd(input logic [2:0] p);
        logic [1:0] nxt;
        nxt = p[1:0] + 2'd1;
        return (p > 3'd3) ? 3'd0 : {1'b0, nxt};
    endfunction

    // One step backward; the first step lands on phase 3.
    function automatic logic [2:0] phase_back(input logic [2:0] p);
        logic [1:0] nxt;
        nxt = p[1:0] - 2'd1;
        return (p > 3'd3) ? 3'd3 : {1'b0, nxt};
    endfunction

    // One-hot coil pattern for a phase.
    function automatic logic [3:0] coil_of(input logic [2:0] p);
        return 4'b0001 << p[1:0];
    endfunction

    // Echo count to centimeters: floor(count*32/29), 0 on fault, 255 at most.
    function automatic logic [7:0] echo_to_cm(input logic [15:0] ticks,
                                              input logic        timeout);
        logic [12:0] num;
        logic [24:0] prod;
        num  = {ticks[7:0], 5'b00000};
        prod = {12'b0, num} * {13'b0, RECIP_29};
        if (timeout || (ticks > ECHO_LIMIT)) begin
            return 8'd0;
        end else if (ticks >= ECHO_SAT_TICKS) begin
            return 8'd255;
        end
        return prod[23:16];
    endfunction

    // Thermometer bar with distance/8 low bits lit.
    function automatic logic [7:0] led_of(input logic [7:0] d);
        logic [4:0] bars;
        logic [7:0] led;
        bars = d[7:3];
        for (int i = 0; i < 8; i++) begin
            led[i] = (bars > 5'(i));
        end
        return led;
    endfunction

endpackage

// ----- rtl/core/stepper_obstacle_avoid_controller_top.sv -----
// ----------------------------------------------------------------------------
// stepper_obstacle_avoid_controller_top
// Two-wheel one-phase stepper controller for an obstacle-avoiding robot.
// ----------------------------------------------------------------------------
// Each request is one event (motor tick, echo measurement, start or stop) and
// produces exactly one result with both coil patterns, the mode, the latest
// distance and an LED bar. A request is taken every cycle while o_ready is high:
// it is held in the input register, its whole effect is computed in one pass of
// logic while it moves into the result register, and throughput is one request
// per cycle, limited only by the downstream ready. Configuration writes take
// effect on the next edge and should be made while no request is in flight.
module stepper_obstacle_avoid_controller_top
    import soac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [7:0]  i_cfg_data,
    // Event request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_echo_ticks,
    input  logic        i_echo_timeout,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_coils_a,
    output logic [3:0]  o_coils_b,
    output logic [1:0]  o_mode,
    output logic [7:0]  o_distance_cm,
    output logic [7:0]  o_led_bar
);

    logic        r_in_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_echo_ticks;
    logic        r_echo_timeout;
    logic [7:0]  r_turn_steps;
    logic [7:0]  r_near_cm;
    t_state      r_state;
    t_state      n_state;
    logic        r_out_valid;
    logic        advance;

    // The held request moves on when the result register is free or drained.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_steps <= TURN_STEPS_RST;
            r_near_cm    <= NEAR_CM_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_TURN_STEPS) begin
                r_turn_steps <= i_cfg_data;
            end else if (i_cfg_addr == CFG_NEAR_CM) begin
                r_near_cm <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind         <= i_kind;
            r_echo_ticks   <= i_echo_ticks;
            r_echo_timeout <= i_echo_timeout;
        end
    end

    // Event logic.
    soac_step u_step (
        .i_cur          (r_state),
        .i_kind         (t_kind'(r_kind)),
        .i_echo_ticks   (r_echo_ticks),
        .i_echo_timeout (r_echo_timeout),
        .i_turn_steps   (r_turn_steps),
        .i_near_cm      (r_near_cm),
        .o_nxt          (n_state)
    );

    // Controller state advances once per processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode       <= MODE_STOP;
            r_state.turn_count <= 8'd0;
            r_state.phase_a    <= PHASE_NONE;
            r_state.phase_b    <= PHASE_NONE;
            r_state.distance   <= 8'd0;
            r_state.drive_a    <= 4'd0;
            r_state.drive_b    <= 4'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_coils_a     <= n_state.drive_a;
            o_coils_b     <= n_state.drive_b;
            o_mode        <= n_state.mode;
            o_distance_cm <= n_state.distance;
            o_led_bar     <= led_of(n_state.distance);
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ----- rtl/core/soac_step.sv -----
// ----------------------------------------------------------------------------
// soac_step
// Next-state logic for one event: mode sequencing, wheel stepping and
// echo-to-distance conversion.
// ----------------------------------------------------------------------------
module soac_step
    import soac_pkg::*;
(
    input  t_state      i_cur,
    input  t_kind       i_kind,
    input  logic [15:0] i_echo_ticks,
    input  logic        i_echo_timeout,
    input  logic [7:0]  i_turn_steps,
    input  logic [7:0]  i_near_cm,
    output t_state      o_nxt
);

    // The tick rule runs turn, then forward, then stop, so a turn that ends
    // falls into the forward action in the same tick.
    always_comb begin
        o_nxt = i_cur;
        case (i_kind)
            KIND_TICK: begin
                if (o_nxt.mode == MODE_TURN) begin
                    if (o_nxt.turn_count == i_turn_steps) begin
                        o_nxt.mode = MODE_FWD;
                    end
                    o_nxt.phase_a    = phase_fwd(o_nxt.phase_a);
                    o_nxt.phase_b    = phase_fwd(o_nxt.phase_b);
                    o_nxt.drive_a    = coil_of(o_nxt.phase_a);
                    o_nxt.drive_b    = coil_of(o_nxt.phase_b);
                    o_nxt.turn_count = o_nxt.turn_count + 8'd1;
                end
                if (o_nxt.mode == MODE_FWD) begin
                    o_nxt.turn_count = 8'd0;
                    if (o_nxt.distance < i_near_cm) begin
                        o_nxt.mode = MODE_TURN;
                    end
                    o_nxt.phase_a = phase_fwd(o_nxt.phase_a);
                    o_nxt.phase_b = phase_back(o_nxt.phase_b);
                    o_nxt.drive_a = coil_of(o_nxt.phase_a);
                    o_nxt.drive_b = coil_of(o_nxt.phase_b);
                end
                if (o_nxt.mode == MODE_STOP) begin
                    o_nxt.turn_count = 8'd0;
                end
            end
            KIND_ECHO: begin
                o_nxt.distance = echo_to_cm(i_echo_ticks, i_echo_timeout);
            end
            KIND_START: begin
                o_nxt.mode = MODE_FWD;
            end
            KIND_STOP: begin
                o_nxt.mode = MODE_STOP;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

// ----- rtl/core/soac_checker.sv -----
// ----------------------------------------------------------------------------
// soac_checker
// Port-level checks for the obstacle-avoiding stepper controller, bound to
// the top level.
// ----------------------------------------------------------------------------
module soac_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        o_ready,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [3:0]  o_coils_a,
    input  logic [3:0]  o_coils_b,
    input  logic [1:0]  o_mode,
    input  logic [7:0]  o_distance_cm,
    input  logic [7:0]  o_led_bar
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_coils_a) && $stable(o_coils_b)
            && $stable(o_mode) && $stable(o_distance_cm) && $stable(o_led_bar))
        else $error("result changed while stalled");

    // A request is never held off while the result side is empty or draining.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("request held off with the result side free");

    // Each wheel drives at most one coil.
    a_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_coils_a) && $onehot0(o_coils_b))
        else $error("more than one coil driven");

    // Once wheel A has been stepped it keeps driving a coil.
    a_coils_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && (o_coils_a != 4'd0) ##1 o_valid |-> (o_coils_a != 4'd0))
        else $error("wheel A coil drive dropped");

    // The LED bar follows the reported distance, and the mode is never 3.
    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_led_bar[0] == (o_distance_cm >= 8'd8))
            && (o_led_bar[3] == (o_distance_cm >= 8'd32))
            && (o_led_bar[7] == (o_distance_cm >= 8'd64))
            && (o_mode != 2'd3))
        else $error("LED bar or mode inconsistent");

endmodule

bind stepper_obstacle_avoid_controller_top soac_checker u_soac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_coils_a     (o_coils_a),
    .o_coils_b     (o_coils_b),
    .o_mode        (o_mode),
    .o_distance_cm (o_distance_cm),
    .o_led_bar     (o_led_bar)
);
